>>> src/hsvr_pkg.sv
// Shared types and constants for the reduced-width HSV to RGB converter.
// No dependencies.
package hsvr_pkg;

	// Hue sector: first letter gets chroma+m, second gets the ramp+m, the third gets m
	typedef enum logic [2:0] {
		SEC_R_G,
		SEC_G_R,
		SEC_G_B,
		SEC_B_G,
		SEC_B_R,
		SEC_R_B
	} sector_t;

	// Sector bounds on the 8-bit hue
	localparam logic [7:0] HUE_B1 = 8'd42;
	localparam logic [7:0] HUE_B2 = 8'd84;
	localparam logic [7:0] HUE_B3 = 8'd127;
	localparam logic [7:0] HUE_B4 = 8'd169;
	localparam logic [7:0] HUE_B5 = 8'd212;
	localparam logic [7:0] HUE_MAX = 8'd254;
	localparam logic [7:0] HUE_PERIOD = 8'd85;
	localparam logic [7:0] HUE_PERIOD2 = 8'd170;
	localparam logic [6:0] RAMP_PEAK = 7'd42;

	// n/255 == (n * 0x8081) >> 23, exact for any 16-bit n
	localparam logic [15:0] RECIP_255 = 16'h8081;
	// n/10710 == (n * 6416385) >> 36, exact for n below 2^22
	localparam logic [22:0] RECIP_RAMP = 23'd6416385;

	typedef struct packed {
		sector_t     sector;
		logic [15:0] chroma;
		logic [15:0] floor_m;
		logic [5:0]  ramp_w;
	} s1_t;

	typedef struct packed {
		sector_t     sector;
		logic [7:0]  c;
		logic [7:0]  mm;
		logic [21:0] ramp;
	} s2_t;

	typedef struct packed {
		sector_t    sector;
		logic [7:0] c;
		logic [7:0] mm;
		logic [7:0] x;
	} s3_t;

endpackage

>>> src/hsvr_ifs.sv
// Valid/ready channel interfaces for HSV pixels in and RGB pixels out.
// No dependencies.
interface hsvr_hsv_if;
	logic       valid;
	logic       ready;
	logic [6:0] hue;
	logic [3:0] saturation;
	logic [2:0] brightness;

	modport source (output valid, hue, saturation, brightness, input ready);
	modport sink (input valid, hue, saturation, brightness, output ready);
endinterface

interface hsvr_rgb_if;
	logic       valid;
	logic       ready;
	logic [4:0] red;
	logic [4:0] green;
	logic [4:0] blue;

	modport source (output valid, red, green, blue, input ready);
	modport sink (input valid, red, green, blue, output ready);
endinterface

>>> src/hsvr_expand.sv
// Stage 1: widen inputs to 8 bits, find sector and ramp weight, form chroma and floor.
// Depends on hsvr_pkg.
module hsvr_expand
	import hsvr_pkg::*;
(
	input  logic       clk,
	input  logic       en,
	input  logic [6:0] hue,
	input  logic [3:0] saturation,
	input  logic [2:0] brightness,
	output s1_t        st_s1
);

	logic [7:0] hue8;
	logic [7:0] hue_raw;
	logic [7:0] sat8;
	logic [7:0] val8;
	logic [7:0] hmod;
	logic [6:0] ramp_dist;
	sector_t    sector;
	s1_t        nxt;

	always_comb begin
		hue_raw = {hue, hue[6]};
		hue8 = (hue_raw == 8'hFF) ? HUE_MAX : hue_raw;
		sat8 = {saturation, saturation};
		// bit 4 is left empty by the expansion
		val8 = {brightness, 1'b0, brightness, brightness[2]};

		if (hue8 >= HUE_PERIOD2) begin
			hmod = hue8 - HUE_PERIOD2;
		end else if (hue8 >= HUE_PERIOD) begin
			hmod = hue8 - HUE_PERIOD;
		end else begin
			hmod = hue8;
		end
		if (hmod[6:0] >= RAMP_PEAK) begin
			ramp_dist = hmod[6:0] - RAMP_PEAK;
		end else begin
			ramp_dist = RAMP_PEAK - hmod[6:0];
		end

		priority if (hue8 < HUE_B1) begin
			sector = SEC_R_G;
		end else if (hue8 < HUE_B2) begin
			sector = SEC_G_R;
		end else if (hue8 < HUE_B3) begin
			sector = SEC_G_B;
		end else if (hue8 < HUE_B4) begin
			sector = SEC_B_G;
		end else if (hue8 < HUE_B5) begin
			sector = SEC_B_R;
		end else begin
			sector = SEC_R_B;
		end

		nxt.sector = sector;
		nxt.chroma = val8 * sat8;
		// 255*val - val*sat
		nxt.floor_m = val8 * (8'hFF - sat8);
		nxt.ramp_w = 6'(RAMP_PEAK - ramp_dist);
	end

	always_ff @(posedge clk) begin
		if (en) begin
			st_s1 <= nxt;
		end
	end

endmodule

>>> src/hsvr_scale.sv
// Stages 2 and 3: divide chroma and floor by 255, form the ramp and divide it by 10710.
// Depends on hsvr_pkg.
module hsvr_scale
	import hsvr_pkg::*;
(
	input  logic clk,
	input  logic en2,
	input  logic en3,
	input  s1_t  st_s1,
	output s3_t  st_s3
);

	s2_t         st_s2;
	logic [31:0] c_prod;
	logic [31:0] m_prod;
	logic [44:0] x_prod;

	always_comb begin
		c_prod = st_s1.chroma * RECIP_255;
		m_prod = st_s1.floor_m * RECIP_255;
		x_prod = st_s2.ramp * RECIP_RAMP;
	end

	always_ff @(posedge clk) begin
		if (en2) begin
			st_s2.sector <= st_s1.sector;
			st_s2.c <= c_prod[30:23];
			st_s2.mm <= m_prod[30:23];
			st_s2.ramp <= st_s1.ramp_w * st_s1.chroma;
		end
	end

	always_ff @(posedge clk) begin
		if (en3) begin
			st_s3.sector <= st_s2.sector;
			st_s3.c <= st_s2.c;
			st_s3.mm <= st_s2.mm;
			st_s3.x <= x_prod[43:36];
		end
	end

endmodule

>>> src/hsvr_mix.sv
// Stage 4: add the floor, route terms to channels by sector, keep the top 5 bits.
// Depends on hsvr_pkg.
module hsvr_mix
	import hsvr_pkg::*;
(
	input  logic       clk,
	input  logic       en,
	input  s3_t        st_s3,
	output logic [4:0] red_s4,
	output logic [4:0] green_s4,
	output logic [4:0] blue_s4
);

	logic [7:0] hi;
	logic [7:0] mid;
	logic [7:0] lo;
	logic [7:0] r8;
	logic [7:0] g8;
	logic [7:0] b8;

	always_comb begin
		hi = st_s3.c + st_s3.mm;
		mid = st_s3.x + st_s3.mm;
		lo = st_s3.mm;
		unique case (st_s3.sector)
			SEC_R_G: begin r8 = hi;  g8 = mid; b8 = lo;  end
			SEC_G_R: begin r8 = mid; g8 = hi;  b8 = lo;  end
			SEC_G_B: begin r8 = lo;  g8 = hi;  b8 = mid; end
			SEC_B_G: begin r8 = lo;  g8 = mid; b8 = hi;  end
			SEC_B_R: begin r8 = mid; g8 = lo;  b8 = hi;  end
			SEC_R_B: begin r8 = hi;  g8 = lo;  b8 = mid; end
			default: begin r8 = lo;  g8 = lo;  b8 = lo;  end
		endcase
	end

	always_ff @(posedge clk) begin
		if (en) begin
			red_s4 <= r8[7:3];
			green_s4 <= g8[7:3];
			blue_s4 <= b8[7:3];
		end
	end

endmodule

>>> src/hsv_to_rgb_reduced_width.sv
// HSV (7/4/3 bits) to RGB (5/5/5 bits) pixel converter, four register stages.
// An accepted pixel passes through the s1, s2, s3 and s4 registers; rgb.valid is the s4 valid bit.
// Throughput: one pixel per clock when not stalled; multipliers (8x8, 16x16, 22x23) set the depth.
// Each stage holds while full and blocked, so bubbles are squeezed out under a stall.
// Reset (arst_n low, asynchronous) clears the stage valid bits only; no data is cleared.
// Depends on hsvr_pkg, hsvr_ifs, hsvr_expand, hsvr_scale, hsvr_mix.
module hsv_to_rgb_reduced_width
	import hsvr_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	hsvr_hsv_if.sink    hsv,
	hsvr_rgb_if.source  rgb
);

	// Stage valid bits
	logic v_s1;
	logic v_s2;
	logic v_s3;
	logic v_s4;

	// A stage may load when it is empty or its content moves on this cycle
	logic adv1;
	logic adv2;
	logic adv3;
	logic adv4;

	s1_t st_s1;
	s3_t st_s3;

	assign adv4 = !v_s4 || rgb.ready;
	assign adv3 = !v_s3 || adv4;
	assign adv2 = !v_s2 || adv3;
	assign adv1 = !v_s1 || adv2;

	assign hsv.ready = adv1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else begin
			if (adv1) v_s1 <= hsv.valid;
			if (adv2) v_s2 <= v_s1;
			if (adv3) v_s3 <= v_s2;
			if (adv4) v_s4 <= v_s3;
		end
	end

	// Expansion, sector, chroma and floor products
	hsvr_expand u_expand (
		.clk        (clk),
		.en         (adv1 && hsv.valid),
		.hue        (hsv.hue),
		.saturation (hsv.saturation),
		.brightness (hsv.brightness),
		.st_s1      (st_s1)
	);

	// Reciprocal divides and ramp product
	hsvr_scale u_scale (
		.clk   (clk),
		.en2   (adv2 && v_s1),
		.en3   (adv3 && v_s2),
		.st_s1 (st_s1),
		.st_s3 (st_s3)
	);

	// Channel routing and output register
	hsvr_mix u_mix (
		.clk      (clk),
		.en       (adv4 && v_s3),
		.st_s3    (st_s3),
		.red_s4   (rgb.red),
		.green_s4 (rgb.green),
		.blue_s4  (rgb.blue)
	);

	assign rgb.valid = v_s4;

`ifndef SYNTHESIS
	// An empty pipeline always takes an item
	a_empty_ready: assert property (@(posedge clk) disable iff (!arst_n)
		(!v_s1 && !v_s2 && !v_s3 && !v_s4) |-> hsv.ready)
		else $error("empty pipeline refuses input");

	// The channels never exceed 29, the largest val8 >> 3 (val8 is at most 239)
	a_out_range: assert property (@(posedge clk) disable iff (!arst_n)
		rgb.valid |-> (rgb.red <= 5'd29 && rgb.green <= 5'd29 && rgb.blue <= 5'd29))
		else $error("output channel out of range");

	// A taken result with nothing behind it leaves the output empty
	a_drain: assert property (@(posedge clk) disable iff (!arst_n)
		(rgb.valid && rgb.ready && !v_s3) |=> !rgb.valid)
		else $error("result repeated after drain");

	// A filled stage 1 item moves to stage 2 when stage 2 is free
	a_advance: assert property (@(posedge clk) disable iff (!arst_n)
		(v_s1 && adv2) |=> v_s2)
		else $error("item lost between stage 1 and stage 2");
`endif

endmodule
